### hdl/spc_pkg.sv
package spc_pkg;

  // Fixed field widths of the vertex and light-matrix formats.
  localparam int COORD_W  = 20;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int POS_W    = 3 * COORD_W;
  localparam int ROW_W    = 62;
  localparam int TERM_W   = 14;
  localparam int TC_W     = 16;
  localparam int IDX_W    = 11;
  localparam int CFG_W    = 62;

  // Shared multiply-accumulate unit and intermediate widths.
  localparam int MAC_A_W  = 44;
  localparam int MAC_B_W  = 22;
  localparam int ACC_W    = 66;
  localparam int NRM_W    = 43;
  localparam int DOT_W    = 36;
  localparam int NUM_W    = 57;
  localparam int DEN_W    = DOT_W;
  localparam int TRANS_SCALE = 8192;

  localparam logic signed [TC_W-1:0] TEX_HALF = 16'sd2048;
  localparam logic signed [TC_W-1:0] TEX_MAX  = 16'sh7fff;
  localparam logic signed [TC_W-1:0] TEX_MIN  = 16'sh8000;

  typedef enum logic [2:0] {
    CFG_CAMERA, CFG_LIGHT, CFG_OBJECT, CFG_U_ROW, CFG_V_ROW, CFG_Z_ROW, CFG_HALF_PERSP
  } cfg_index_t;

  typedef enum logic {
    OP_FRAME  = 1'b0,
    OP_VERTEX = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_EMIT  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_FRAME = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CROSS, S_SIDE, S_DOT, S_NUM, S_DIV, S_OUT
  } state_t;

  typedef struct packed {
    logic [POS_W-1:0] camera;
    logic [POS_W-1:0] light;
    logic [POS_W-1:0] object;
    logic [ROW_W-1:0] u_row;
    logic [ROW_W-1:0] v_row;
    logic [ROW_W-1:0] z_row;
    logic [15:0]      half_persp;
  } cfg_t;

  typedef struct packed {
    logic                      start;
    logic                      clr;
    logic                      neg;
    logic signed [MAC_A_W-1:0] a;
    logic signed [MAC_B_W-1:0] b;
  } mac_req_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
  } div_req_t;

  // One signed coordinate out of a packed x,y,z position.
  function automatic logic signed [COORD_W-1:0] coord(input logic [POS_W-1:0] p,
                                                      input logic [1:0] k);
    return p[COORD_W*k +: COORD_W];
  endfunction

  // Difference of two coordinates, one bit wider.
  function automatic logic signed [DIFF_W-1:0] diff(input logic signed [COORD_W-1:0] a,
                                                    input logic signed [COORD_W-1:0] b);
    return $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
  endfunction

  // One Q1.13 matrix term of a row.
  function automatic logic signed [TERM_W-1:0] row_term(input logic [ROW_W-1:0] row,
                                                        input logic [1:0] k);
    return row[TERM_W*k +: TERM_W];
  endfunction

endpackage

### hdl/spc_mac.sv
module spc_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  spc_pkg::mac_req_t                   req,
  output logic signed [spc_pkg::ACC_W-1:0]    acc,
  output logic                                done
);

  localparam int CNT_W = $clog2(spc_pkg::MAC_B_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(spc_pkg::MAC_B_W - 1);

  logic                              busy;
  logic [CNT_W-1:0]                  cnt;
  logic signed [spc_pkg::ACC_W-1:0]  a_sh;
  logic [spc_pkg::MAC_B_W-1:0]       b_sh;
  logic signed [spc_pkg::ACC_W-1:0]  a_ext;

  assign a_ext = spc_pkg::ACC_W'(req.a);

  // Shift-add multiply, one multiplier bit per cycle; the top bit carries negative weight.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (!busy && req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        a_sh <= req.neg ? -a_ext : a_ext;
        b_sh <= req.b;
        if (req.clr) begin
          acc <= '0;
        end
      end else if (busy) begin
        if (b_sh[0]) begin
          acc <= (cnt == LAST) ? acc - a_sh : acc + a_sh;
        end
        a_sh <= a_sh <<< 1;
        b_sh <= b_sh >> 1;
        cnt  <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### hdl/spc_div.sv
module spc_div (
  input  logic                              clk,
  input  logic                              rst,
  input  spc_pkg::div_req_t                 req,
  output logic signed [spc_pkg::TC_W-1:0]   tex,
  output logic                              done
);

  localparam int NA_W = spc_pkg::NUM_W;
  localparam int DA_W = spc_pkg::DEN_W;
  localparam int N_W  = NA_W + 1;
  localparam int D_W  = DA_W + 1;
  localparam int Q_W  = 16;

  logic [NA_W-1:0]    an;
  logic [DA_W-1:0]    ad;
  logic [N_W-1:0]     n_full;
  logic [D_W-1:0]     d_full;
  logic               ovf;
  logic               neg_c;

  logic               busy;
  logic               neg;
  logic [4:0]         cnt;
  logic [D_W-1:0]     dreg;
  logic [D_W-1:0]     rem;
  logic [Q_W-1:0]     nlow;
  logic [Q_W-1:0]     q;
  logic [D_W:0]       trial;
  logic signed [Q_W+1:0] qv;
  logic signed [Q_W+1:0] v;

  // Magnitudes and the rounded dividend 2|n| + |d| over divisor 2|d|.
  always_comb begin
    an     = req.num[NA_W-1] ? (~req.num + 1'b1) : req.num;
    ad     = req.den[DA_W-1] ? (~req.den + 1'b1) : req.den;
    n_full = {an, 1'b0} + N_W'(ad);
    d_full = {ad, 1'b0};
    ovf    = n_full[N_W-1:Q_W] >= (N_W-Q_W)'(d_full);
    neg_c  = req.num[NA_W-1] ^ req.den[DA_W-1];
    trial  = {rem, nlow[Q_W-1]};
    qv     = {2'b00, q};
    v      = (neg ? -qv : qv) + (Q_W+2)'(spc_pkg::TEX_HALF);
  end

  // Restoring long division over the low 16 quotient bits; larger quotients saturate.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (!busy && req.start) begin
        neg <= neg_c;
        if (req.den == '0) begin
          tex  <= (req.num == '0) ? spc_pkg::TEX_HALF :
                  (req.num[NA_W-1] ? spc_pkg::TEX_MIN : spc_pkg::TEX_MAX);
          done <= 1'b1;
        end else if (ovf) begin
          tex  <= neg_c ? spc_pkg::TEX_MIN : spc_pkg::TEX_MAX;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= '0;
          dreg <= d_full;
          rem  <= n_full[Q_W+D_W-1:Q_W];
          nlow <= n_full[Q_W-1:0];
          q    <= '0;
        end
      end else if (busy) begin
        if (cnt == 5'(Q_W)) begin
          if (v > (Q_W+2)'(spc_pkg::TEX_MAX)) begin
            tex <= spc_pkg::TEX_MAX;
          end else if (v < (Q_W+2)'(spc_pkg::TEX_MIN)) begin
            tex <= spc_pkg::TEX_MIN;
          end else begin
            tex <= v[Q_W-1:0];
          end
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          if (trial >= {1'b0, dreg}) begin
            rem <= D_W'(trial - {1'b0, dreg});
            q   <= {q[Q_W-2:0], 1'b1};
          end else begin
            rem <= trial[D_W-1:0];
            q   <= {q[Q_W-2:0], 1'b0};
          end
          nlow <= nlow << 1;
          cnt  <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

### hdl/spc_ctrl.sv
module spc_ctrl #(
  parameter int BUFFER_VERTS   = 1024,
  parameter int MAX_POLY_VERTS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  spc_pkg::cfg_t                     cfg,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [71:0]                       s_tdata,
  input  logic [1:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [103:0]                      m_tdata,
  output logic [1:0]                        m_tuser,
  output logic                              m_tlast,
  output spc_pkg::mac_req_t                 mac_req,
  input  logic signed [spc_pkg::ACC_W-1:0]  mac_acc,
  input  logic                              mac_done,
  output spc_pkg::div_req_t                 div_req,
  input  logic signed [spc_pkg::TC_W-1:0]   div_tex,
  input  logic                              div_done
);

  localparam int CNT_W = $clog2(BUFFER_VERTS + 1);
  localparam int SZ_W  = $clog2(MAX_POLY_VERTS + 1);
  localparam int CW    = (SZ_W > 5) ? SZ_W : 5;
  localparam int CMP_W = CNT_W + SZ_W + 2;
  localparam int POS_W = spc_pkg::POS_W;
  localparam int TCP_W = 2 * spc_pkg::TC_W;

  spc_pkg::state_t state, state_next;

  // Polygon and buffer bookkeeping.
  logic [CNT_W-1:0]  count;
  logic [SZ_W-1:0]   pindex;
  logic [SZ_W-1:0]   psize;
  logic              paccepted;

  // Vertex and texture coordinate stores.
  logic [POS_W-1:0]  held_pos [0:1];
  logic [TCP_W-1:0]  held_tc  [0:1];
  logic [POS_W-1:0]  prev_pos;
  logic [TCP_W-1:0]  prev_tc;
  logic [POS_W-1:0]  pos_cur;
  logic [TCP_W-1:0]  cur_tc;
  logic              is_first;

  // Sequencer working registers.
  logic [1:0]        major;
  logic [1:0]        minor;
  logic              mac_issued;
  logic              div_issued;
  logic [1:0]        tex_sel;
  logic signed [spc_pkg::NRM_W-1:0] nrm [0:2];
  logic              side_neg [0:1];
  logic              side_pos [0:1];
  logic signed [spc_pkg::DOT_W-1:0] dot [0:2];
  logic signed [spc_pkg::NUM_W-1:0] num;
  logic [spc_pkg::TC_W-1:0] tc_u;
  logic [1:0]        res_idx;
  spc_pkg::status_t  res_kind;

  // Combinational helpers.
  logic              acc_in;
  logic              op_vertex;
  logic              pstart;
  logic [CW-1:0]     cnt_in;
  logic [SZ_W-1:0]   size_clamp;
  logic [SZ_W-1:0]   idx_eff;
  logic [SZ_W-1:0]   size_eff;
  logic              accd_eff;
  logic              in_range;
  logic signed [spc_pkg::DIFF_W-1:0] e1 [0:2];
  logic signed [spc_pkg::DIFF_W-1:0] e2 [0:2];
  logic [1:0]        ia;
  logic [1:0]        ib;
  logic [POS_W-1:0]  side_pt;
  logic [spc_pkg::ROW_W-1:0] row_sel;
  logic [POS_W-1:0]  tex_pos;
  logic              acc_neg;
  logic              acc_pos;
  logic              culled;
  logic              full;
  logic              out_load;
  logic              out_last;
  logic [POS_W-1:0]  res_pos;
  logic [TCP_W-1:0]  res_tc;
  logic [CNT_W+10:0] cnt_wide;
  logic [spc_pkg::IDX_W-1:0] res_index;

  // Input decode and polygon counters as seen by the incoming request.
  always_comb begin
    acc_in    = s_tvalid && s_tready;
    op_vertex = (spc_pkg::op_t'(s_tuser[0]) == spc_pkg::OP_VERTEX);
    pstart    = s_tuser[1];
    cnt_in    = CW'(s_tdata[64:60]);
    if (cnt_in < CW'(3)) begin
      size_clamp = SZ_W'(3);
    end else if (cnt_in > CW'(MAX_POLY_VERTS)) begin
      size_clamp = SZ_W'(MAX_POLY_VERTS);
    end else begin
      size_clamp = SZ_W'(cnt_in);
    end
    idx_eff  = pstart ? '0 : pindex;
    size_eff = pstart ? size_clamp : psize;
    accd_eff = pstart ? 1'b0 : paccepted;
    in_range = idx_eff < size_eff;
  end

  // Edge vectors, operand selection and plane tests.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1[k] = spc_pkg::diff(spc_pkg::coord(held_pos[1], 2'(k)),
                            spc_pkg::coord(held_pos[0], 2'(k)));
      e2[k] = spc_pkg::diff(spc_pkg::coord(pos_cur, 2'(k)),
                            spc_pkg::coord(held_pos[0], 2'(k)));
    end
    unique case ({major, minor})
      4'b0000: begin ia = 2'd1; ib = 2'd2; end
      4'b0001: begin ia = 2'd2; ib = 2'd1; end
      4'b0100: begin ia = 2'd2; ib = 2'd0; end
      4'b0101: begin ia = 2'd0; ib = 2'd2; end
      4'b1000: begin ia = 2'd0; ib = 2'd1; end
      4'b1001: begin ia = 2'd1; ib = 2'd0; end
      default: begin ia = 2'd0; ib = 2'd0; end
    endcase
    unique case (major)
      2'd0:    begin side_pt = cfg.camera; row_sel = cfg.u_row; end
      2'd1:    begin side_pt = cfg.light;  row_sel = cfg.v_row; end
      default: begin side_pt = cfg.object; row_sel = cfg.z_row; end
    endcase
    unique case (tex_sel)
      2'd0:    tex_pos = held_pos[0];
      2'd1:    tex_pos = held_pos[1];
      default: tex_pos = pos_cur;
    endcase
    acc_neg  = mac_acc[spc_pkg::ACC_W-1];
    acc_pos  = !mac_acc[spc_pkg::ACC_W-1] && (mac_acc != '0);
    culled   = (side_neg[0] && side_pos[1]) || (side_pos[0] && side_neg[1]) ||
               (acc_neg && side_pos[1]) || (acc_pos && side_neg[1]);
    full     = (CMP_W'(count) + CMP_W'(psize - SZ_W'(2)) * CMP_W'(3)) >
               CMP_W'(BUFFER_VERTS);
  end

  // Result selection for the output register.
  always_comb begin
    cnt_wide  = {11'b0, count};
    res_index = cnt_wide[10:0];
    res_pos   = '0;
    res_tc    = '0;
    out_last  = 1'b1;
    unique case (res_kind)
      spc_pkg::STATUS_EMIT: begin
        out_last = (res_idx == 2'd2);
        unique case (res_idx)
          2'd0:    begin res_pos = held_pos[0]; res_tc = held_tc[0]; end
          2'd1:    begin
            res_pos = is_first ? held_pos[1] : prev_pos;
            res_tc  = is_first ? held_tc[1]  : prev_tc;
          end
          default: begin res_pos = pos_cur; res_tc = cur_tc; end
        endcase
      end
      spc_pkg::STATUS_FULL: ;
      default: res_index = '0;
    endcase
    out_load = (state == spc_pkg::S_OUT) && (!m_tvalid || m_tready);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      spc_pkg::S_IDLE: begin
        if (acc_in) begin
          if (!op_vertex) begin
            state_next = spc_pkg::S_OUT;
          end else if (in_range && idx_eff == SZ_W'(2)) begin
            state_next = spc_pkg::S_CROSS;
          end else if (in_range && idx_eff > SZ_W'(2) && accd_eff) begin
            state_next = spc_pkg::S_DOT;
          end
        end
      end
      spc_pkg::S_CROSS: begin
        if (mac_done && major == 2'd2 && minor == 2'd1) state_next = spc_pkg::S_SIDE;
      end
      spc_pkg::S_SIDE: begin
        if (mac_done && major == 2'd2 && minor == 2'd2) begin
          priority if (culled) state_next = spc_pkg::S_IDLE;
          else if (full)       state_next = spc_pkg::S_OUT;
          else                 state_next = spc_pkg::S_DOT;
        end
      end
      spc_pkg::S_DOT: begin
        if (mac_done && major == 2'd2 && minor == 2'd3) state_next = spc_pkg::S_NUM;
      end
      spc_pkg::S_NUM: begin
        if (mac_done) state_next = spc_pkg::S_DIV;
      end
      spc_pkg::S_DIV: begin
        if (div_done) begin
          priority if (major == 2'd0) state_next = spc_pkg::S_NUM;
          else if (tex_sel == 2'd2)   state_next = spc_pkg::S_OUT;
          else                        state_next = spc_pkg::S_DOT;
        end
      end
      spc_pkg::S_OUT: begin
        if (out_load && out_last) state_next = spc_pkg::S_IDLE;
      end
      default: state_next = spc_pkg::S_IDLE;
    endcase
  end

  // Handshake and requests to the shared units.
  always_comb begin
    s_tready = (state == spc_pkg::S_IDLE);
    mac_req  = '0;
    div_req  = '0;
    unique case (state)
      spc_pkg::S_CROSS: begin
        mac_req.start = !mac_issued;
        mac_req.clr   = (minor == 2'd0);
        mac_req.neg   = (minor == 2'd1);
        mac_req.a     = spc_pkg::MAC_A_W'(e1[ia]);
        mac_req.b     = spc_pkg::MAC_B_W'(e2[ib]);
      end
      spc_pkg::S_SIDE: begin
        mac_req.start = !mac_issued;
        mac_req.clr   = (minor == 2'd0);
        mac_req.a     = spc_pkg::MAC_A_W'(nrm[minor]);
        mac_req.b     = spc_pkg::MAC_B_W'(spc_pkg::diff(spc_pkg::coord(side_pt, minor),
                                                        spc_pkg::coord(held_pos[0], minor)));
      end
      spc_pkg::S_DOT: begin
        mac_req.start = !mac_issued;
        mac_req.clr   = (minor == 2'd0);
        if (minor == 2'd0) begin
          mac_req.a = spc_pkg::MAC_A_W'($signed(row_sel[61:42]));
          mac_req.b = spc_pkg::MAC_B_W'(spc_pkg::TRANS_SCALE);
        end else begin
          mac_req.a = spc_pkg::MAC_A_W'(spc_pkg::coord(tex_pos, minor - 2'd1));
          mac_req.b = spc_pkg::MAC_B_W'(spc_pkg::row_term(row_sel, minor - 2'd1));
        end
      end
      spc_pkg::S_NUM: begin
        mac_req.start = !mac_issued;
        mac_req.clr   = 1'b1;
        mac_req.neg   = major[0];
        mac_req.a     = spc_pkg::MAC_A_W'(major[0] ? dot[1] : dot[0]);
        mac_req.b     = spc_pkg::MAC_B_W'($signed({1'b0, cfg.half_persp}));
      end
      spc_pkg::S_DIV: begin
        div_req.start = !div_issued;
        div_req.num   = num;
        div_req.den   = dot[2];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer counters and polygon bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      pindex     <= '0;
      psize      <= '0;
      paccepted  <= 1'b0;
      major      <= '0;
      minor      <= '0;
      mac_issued <= 1'b0;
      div_issued <= 1'b0;
      tex_sel    <= '0;
      res_idx    <= '0;
      res_kind   <= spc_pkg::STATUS_EMIT;
      m_tvalid   <= 1'b0;
    end else begin
      if (mac_req.start) begin
        mac_issued <= 1'b1;
      end else if (mac_done) begin
        mac_issued <= 1'b0;
      end
      if (div_req.start) begin
        div_issued <= 1'b1;
      end else if (div_done) begin
        div_issued <= 1'b0;
      end

      if (acc_in) begin
        major   <= '0;
        minor   <= '0;
        res_idx <= '0;
        if (!op_vertex) begin
          count     <= '0;
          pindex    <= '0;
          psize     <= '0;
          paccepted <= 1'b0;
          res_kind  <= spc_pkg::STATUS_FRAME;
        end else begin
          psize     <= size_eff;
          paccepted <= accd_eff;
          pindex    <= in_range ? idx_eff + 1'b1 : idx_eff;
          res_kind  <= spc_pkg::STATUS_EMIT;
          tex_sel   <= (idx_eff == SZ_W'(2)) ? 2'd0 : 2'd2;
        end
      end

      // Step through the operations of each phase as the shared units finish.
      if (mac_done) begin
        unique case (state)
          spc_pkg::S_CROSS: begin
            minor <= (minor == 2'd1) ? 2'd0 : 2'd1;
            if (minor == 2'd1) major <= (major == 2'd2) ? 2'd0 : major + 1'b1;
          end
          spc_pkg::S_SIDE: begin
            minor <= (minor == 2'd2) ? 2'd0 : minor + 1'b1;
            if (minor == 2'd2) major <= (major == 2'd2) ? 2'd0 : major + 1'b1;
            if (minor == 2'd2 && major == 2'd2) begin
              priority if (culled) begin
                paccepted <= 1'b0;
              end else if (full) begin
                paccepted <= 1'b0;
                res_kind  <= spc_pkg::STATUS_FULL;
              end else begin
                paccepted <= 1'b1;
              end
            end
          end
          spc_pkg::S_DOT: begin
            minor <= minor + 1'b1;
            if (minor == 2'd3) major <= (major == 2'd2) ? 2'd0 : major + 1'b1;
          end
          default: ;
        endcase
      end

      if (div_done && state == spc_pkg::S_DIV) begin
        if (major == 2'd0) begin
          major <= 2'd1;
        end else begin
          major <= 2'd0;
          if (tex_sel != 2'd2) tex_sel <= tex_sel + 1'b1;
        end
      end

      // Output register: a finished result waits here until it is taken.
      if (out_load) begin
        m_tvalid <= 1'b1;
        res_idx  <= res_idx + 1'b1;
        if (res_kind == spc_pkg::STATUS_EMIT) count <= count + 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Vertex data, partial results and output payload.
  always_ff @(posedge clk) begin
    if (acc_in && op_vertex && in_range) begin
      if (idx_eff < SZ_W'(2)) begin
        held_pos[idx_eff[0]] <= s_tdata[POS_W-1:0];
      end else begin
        pos_cur  <= s_tdata[POS_W-1:0];
        is_first <= (idx_eff == SZ_W'(2));
      end
    end
    if (mac_done) begin
      unique case (state)
        spc_pkg::S_CROSS: if (minor == 2'd1) nrm[major] <= mac_acc[spc_pkg::NRM_W-1:0];
        spc_pkg::S_SIDE: begin
          if (minor == 2'd2 && major != 2'd2) begin
            side_neg[major[0]] <= acc_neg;
            side_pos[major[0]] <= acc_pos;
          end
        end
        spc_pkg::S_DOT: if (minor == 2'd3) dot[major] <= mac_acc[spc_pkg::DOT_W-1:0];
        spc_pkg::S_NUM: num <= {mac_acc[spc_pkg::NUM_W-5:0], 4'b0000};
        default: ;
      endcase
    end
    if (div_done && state == spc_pkg::S_DIV) begin
      if (major == 2'd0) begin
        tc_u <= div_tex;
      end else begin
        unique case (tex_sel)
          2'd0:    held_tc[0] <= {div_tex, tc_u};
          2'd1:    held_tc[1] <= {div_tex, tc_u};
          default: cur_tc     <= {div_tex, tc_u};
        endcase
      end
    end
    if (out_load) begin
      m_tdata <= {1'b0, res_index, res_tc, res_pos};
      m_tuser <= res_kind;
      m_tlast <= out_last;
      if (res_kind == spc_pkg::STATUS_EMIT && out_last) begin
        prev_pos <= pos_cur;
        prev_tc  <= cur_tc;
      end
    end
  end

  // The sequencer never takes a request while a shared unit still works for it.
  assert property (@(posedge clk) disable iff (rst) s_tready |-> !mac_issued && !div_issued)
    else $error("request taken while a shared unit is busy");

  // Multiplier and divider are never in use at once.
  assert property (@(posedge clk) disable iff (rst) !(mac_issued && div_issued))
    else $error("multiplier and divider active together");

  // The capacity check keeps the buffer fill in bounds.
  assert property (@(posedge clk) disable iff (rst)
                   CMP_W'(count) <= CMP_W'(BUFFER_VERTS))
    else $error("vertex buffer fill beyond capacity");

  // The vertex position within a polygon never passes its size.
  assert property (@(posedge clk) disable iff (rst) pindex <= psize)
    else $error("polygon index beyond polygon size");

endmodule

### hdl/shadow_polygon_cull_and_project_core.sv
// Shadow polygon culling and projective texture coordinate generation. Vertices
// arrive one request at a time; the block is busy on each request and takes the
// next only once its work is done. A frame command or the first two vertices of a
// polygon need no arithmetic. The third vertex runs the face normal and three plane
// tests on the shared serial 22-bit multiply-accumulate unit (15 operations); an
// accepted polygon then projects three vertices, each with 14 multiply-accumulate
// operations and two divisions. Every later vertex of an accepted polygon is
// projected alone in the same way. Results leave through a registered output
// stage, up to three per vertex, and the block waits while that stage is stalled.
module shadow_polygon_cull_and_project_core #(
  parameter int BUFFER_VERTS   = 1024,
  parameter int MAX_POLY_VERTS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [61:0]   cfg_data,
  input  logic          s_tvalid,
  output logic          s_tready,
  // vertex_x[19:0], vertex_y[39:20], vertex_z[59:40], polygon_vertex_count[64:60], zero pad
  input  logic [71:0]   s_tdata,
  // opcode[0], polygon_start[1]
  input  logic [1:0]    s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  // out_x[19:0], out_y[39:20], out_z[59:40], tex_u[75:60], tex_v[91:76],
  // buffer_index[102:92], zero pad
  output logic [103:0]  m_tdata,
  // status[1:0]
  output logic [1:0]    m_tuser,
  output logic          m_tlast
);

  spc_pkg::cfg_t                          cfg;
  spc_pkg::mac_req_t                      mac_req;
  spc_pkg::div_req_t                      div_req;
  logic signed [spc_pkg::ACC_W-1:0]       mac_acc;
  logic                                   mac_done;
  logic signed [spc_pkg::TC_W-1:0]        div_tex;
  logic                                   div_done;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg            <= '0;
      cfg.half_persp <= 16'd256;
    end else if (cfg_we) begin
      unique case (spc_pkg::cfg_index_t'(cfg_index))
        spc_pkg::CFG_CAMERA:     cfg.camera     <= cfg_data[spc_pkg::POS_W-1:0];
        spc_pkg::CFG_LIGHT:      cfg.light      <= cfg_data[spc_pkg::POS_W-1:0];
        spc_pkg::CFG_OBJECT:     cfg.object     <= cfg_data[spc_pkg::POS_W-1:0];
        spc_pkg::CFG_U_ROW:      cfg.u_row      <= cfg_data;
        spc_pkg::CFG_V_ROW:      cfg.v_row      <= cfg_data;
        spc_pkg::CFG_Z_ROW:      cfg.z_row      <= cfg_data;
        spc_pkg::CFG_HALF_PERSP: cfg.half_persp <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  spc_ctrl #(
    .BUFFER_VERTS   (BUFFER_VERTS),
    .MAX_POLY_VERTS (MAX_POLY_VERTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .mac_req  (mac_req),
    .mac_acc  (mac_acc),
    .mac_done (mac_done),
    .div_req  (div_req),
    .div_tex  (div_tex),
    .div_done (div_done)
  );

  spc_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .req  (mac_req),
    .acc  (mac_acc),
    .done (mac_done)
  );

  spc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .tex  (div_tex),
    .done (div_done)
  );

endmodule
